// ===== design/assert_macros.svh =====
// assertion macros used by the index/data configuration register block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== design/idcr_pkg.sv =====
// types and constants of the index/data configuration port block
package idcr_pkg;

   localparam logic [15:0] INDEX_PORT_RESET = 16'd46;
   localparam logic [15:0] DATA_PORT_RESET  = 16'd47;
   localparam logic [7:0]  ENTER_KEY_RESET  = 8'd85;
   localparam logic [7:0]  EXIT_KEY_RESET   = 8'd170;

   localparam int unsigned BANK_SIZE = 256;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_PORT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_PORT  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_KEY  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_KEY   = 8'd3;

   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      SRC_ZERO   = 2'd0,
      SRC_GLOBAL = 2'd1,
      SRC_DEVICE = 2'd2
   } read_src_type;

endpackage

// ===== design/index_data_config_registers.sv =====
// index/data configuration port pair with global and logical device registers
//
// request channel: req_valid/req_stall carry one byte access (action, port address,
// write data); a request is taken at an edge with req_valid high and req_stall low.
// response channel: rsp_valid/rsp_stall return one response per request, in order,
// with read_data, handled and the configuration mode flag after the access.
// csr channel: csr_valid/csr_ready write the port addresses and the keys; csr_ready
// is always high, writes are meant for idle periods.
// stages: read stage in the synchronous register memories, then the output register.
// throughput: one request per cycle while req_stall is low; state updates at the edge
// that takes a request.
// reset: synchronous, active high; port addresses and keys return to their defaults,
// the global registers read as defaults through per-entry valid bits, and the device
// memory is swept to zero over its DEVICE_TOTAL*256 entries (4096 by default), while
// req_stall stays high.
// stall: a held response keeps its value; one more request is taken into the memory
// read stage, after which req_stall rises until the response is taken.
module index_data_config_registers #(
   parameter int unsigned GLOBAL_COUNT        = 48,
   parameter int unsigned DEVICE_TOTAL        = 16,
   parameter int unsigned DEVICE_SELECT_INDEX = 7,
   parameter int unsigned BASE_LOW_INDEX      = 38,
   parameter int unsigned BASE_HIGH_INDEX     = 39
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [15:0]                         req_port_address,
   input  logic [7:0]                          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_handled,
   output logic                                rsp_config_mode,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [idcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [idcr_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import idcr_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned GW        = $clog2(GLOBAL_COUNT);
   localparam int unsigned DEV_DEPTH = DEVICE_TOTAL * BANK_SIZE;
   localparam int unsigned ADDR_W    = $clog2(DEV_DEPTH);

   function automatic logic [7:0] glob_reset_value(input logic [7:0] idx);
      logic [7:0] value;
      value = 8'd0;
      if (BASE_LOW_INDEX < GLOBAL_COUNT && idx == 8'(BASE_LOW_INDEX))
         value = INDEX_PORT_RESET[7:0];
      else if (BASE_HIGH_INDEX < GLOBAL_COUNT && idx == 8'(BASE_HIGH_INDEX))
         value = INDEX_PORT_RESET[15:8];
      return value;
   endfunction

   localparam logic [7:0] DEV_SEL_RESET =
      (DEVICE_SELECT_INDEX < GLOBAL_COUNT) ? glob_reset_value(8'(DEVICE_SELECT_INDEX)) : 8'd0;

   // csr registers
   logic [15:0] index_port_ff, index_port_in;
   logic [15:0] data_port_ff, data_port_in;
   logic [7:0]  enter_key_ff, enter_key_in;
   logic [7:0]  exit_key_ff, exit_key_in;

   // control state
   logic [7:0]              sel_ff, sel_in;
   logic                    mode_ff, mode_in;
   logic [7:0]              dev_sel_ff, dev_sel_in;
   logic [GLOBAL_COUNT-1:0] gvalid_ff, gvalid_in;
   logic                    clear_ff, clear_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;

   // memories and read data
   logic [7:0] glob_mem_ff [GLOBAL_COUNT];
   logic [7:0] dev_mem_ff [DEV_DEPTH];
   logic [7:0] glob_rd_ff;
   logic [7:0] dev_rd_ff;
   logic       glob_rd_valid_ff;
   logic [7:0] glob_rd_reset_ff;

   // read stage and output register
   logic         s1_valid_ff, s1_valid_in;
   read_src_type s1_src_ff;
   logic         s1_handled_ff;
   logic         s1_mode_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_read_data_ff;
   logic         rsp_handled_ff;
   logic         rsp_config_mode_ff;

   logic              accept, out_free, s1_move;
   logic              idx_hit, data_hit, is_glob, dev_ok;
   logic [7:0]        dev_num;
   logic [GW-1:0]     gidx;
   logic [ADDR_W-1:0] dev_addr;
   logic              glob_we, glob_re, dev_we_req, dev_re, dev_we;
   logic [ADDR_W-1:0] dev_wa;
   logic [7:0]        dev_wd;
   read_src_type      src;
   logic [7:0]        s1_data;

   assign csr_ready = 1'b1;

   always_comb begin
      index_port_in = index_port_ff;
      data_port_in  = data_port_ff;
      enter_key_in  = enter_key_ff;
      exit_key_in   = exit_key_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INDEX_PORT: index_port_in = csr_write_data;
            CSR_DATA_PORT:  data_port_in  = csr_write_data;
            CSR_ENTER_KEY:  enter_key_in  = csr_write_data[7:0];
            CSR_EXIT_KEY:   exit_key_in   = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = clear_ff || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   // decode
   assign idx_hit  = (req_port_address == index_port_ff);
   assign data_hit = !idx_hit && (req_port_address == data_port_ff);
   assign is_glob  = (sel_ff < 8'(GLOBAL_COUNT));
   assign dev_num  = (DEVICE_SELECT_INDEX < GLOBAL_COUNT) ? dev_sel_ff : 8'd0;
   assign dev_ok   = ({1'b0, dev_num} < 9'(DEVICE_TOTAL));
   assign gidx     = sel_ff[GW-1:0];
   assign dev_addr = ADDR_W'({dev_num, sel_ff});

   assign glob_we    = accept && data_hit && is_glob && req_action;
   assign glob_re    = accept && data_hit && is_glob && !req_action;
   assign dev_we_req = accept && data_hit && !is_glob && dev_ok && req_action;
   assign dev_re     = accept && data_hit && !is_glob && dev_ok && !req_action;

   assign dev_we = clear_ff || dev_we_req;
   assign dev_wa = clear_ff ? clr_addr_ff : dev_addr;
   assign dev_wd = clear_ff ? 8'd0 : req_write_data;

   always_comb begin
      priority if (glob_re)
         src = SRC_GLOBAL;
      else if (dev_re)
         src = SRC_DEVICE;
      else
         src = SRC_ZERO;
   end

   always_comb begin
      sel_in     = sel_ff;
      mode_in    = mode_ff;
      dev_sel_in = dev_sel_ff;
      gvalid_in  = gvalid_ff;
      if (accept && idx_hit && req_action) begin
         priority if (req_write_data == enter_key_ff)
            mode_in = 1'b1;
         else if (req_write_data == exit_key_ff)
            mode_in = 1'b0;
         else
            sel_in = req_write_data;
      end
      if (glob_we) begin
         gvalid_in[gidx] = 1'b1;
         if (sel_ff == 8'(DEVICE_SELECT_INDEX))
            dev_sel_in = req_write_data;
      end
   end

   // device memory sweep after reset
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clear_in    = clear_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEV_DEPTH - 1))
            clear_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)
         s1_valid_in = 1'b1;
      else if (s1_move)
         s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_move)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_comb begin
      unique case (s1_src_ff)
         SRC_GLOBAL: s1_data = glob_rd_valid_ff ? glob_rd_ff : glob_rd_reset_ff;
         SRC_DEVICE: s1_data = dev_rd_ff;
         default:    s1_data = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_port_ff <= INDEX_PORT_RESET;
         data_port_ff  <= DATA_PORT_RESET;
         enter_key_ff  <= ENTER_KEY_RESET;
         exit_key_ff   <= EXIT_KEY_RESET;
         sel_ff        <= 8'd0;
         mode_ff       <= 1'b0;
         dev_sel_ff    <= DEV_SEL_RESET;
         gvalid_ff     <= '0;
         clear_ff      <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         index_port_ff <= index_port_in;
         data_port_ff  <= data_port_in;
         enter_key_ff  <= enter_key_in;
         exit_key_ff   <= exit_key_in;
         sel_ff        <= sel_in;
         mode_ff       <= mode_in;
         dev_sel_ff    <= dev_sel_in;
         gvalid_ff     <= gvalid_in;
         clear_ff      <= clear_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // global register memory
   always_ff @(posedge clock) begin
      if (glob_we)
         glob_mem_ff[gidx] <= req_write_data;
      if (glob_re) begin
         glob_rd_ff       <= glob_mem_ff[gidx];
         glob_rd_valid_ff <= gvalid_ff[gidx];
         glob_rd_reset_ff <= glob_reset_value(sel_ff);
      end
   end

   // device bank memory
   always_ff @(posedge clock) begin
      if (dev_we)
         dev_mem_ff[dev_wa] <= dev_wd;
      if (dev_re)
         dev_rd_ff <= dev_mem_ff[dev_addr];
   end

   // payload of read stage and output register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff     <= src;
         s1_handled_ff <= idx_hit || data_hit;
         s1_mode_ff    <= mode_in;
      end
      if (s1_move) begin
         rsp_read_data_ff   <= s1_data;
         rsp_handled_ff     <= s1_handled_ff;
         rsp_config_mode_ff <= s1_mode_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_handled     = rsp_handled_ff;
   assign rsp_config_mode = rsp_config_mode_ff;

   `ASSERT_SAME(a_no_request_in_sweep, clock, reset, clear_ff, req_stall && !accept, "request taken during memory sweep")
   `ASSERT_NEXT(a_taken_reaches_stage, clock, reset, accept, s1_valid_ff, "taken request lost before read stage")
   `ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall, s1_valid_ff, "read stage dropped while output stalled")
   `ASSERT_SAME(a_single_mem_access, clock, reset, accept, !(glob_we && glob_re) && !(dev_we_req && dev_re), "read and write in one access")

endmodule
